// ===== design/mgp_pkg.sv =====
// Package for the masked global pooling block: widths, constants and the sequencer states.
// Used by masked_global_pooling and by its checker. Depends on nothing else.
package mgp_pkg;

    localparam int MAX_PLANE_ELEMENTS = 4096;
    localparam int SAMPLE_WIDTH       = 16;

    // The count must be able to hold the plane limit itself.
    localparam int CNT_WIDTH  = $clog2(MAX_PLANE_ELEMENTS + 1);
    // The exact sum of MAX_PLANE_ELEMENTS signed samples.
    localparam int SUM_WIDTH  = SAMPLE_WIDTH + $clog2(MAX_PLANE_ELEMENTS) + 1;
    localparam int STEP_WIDTH = $clog2(SUM_WIDTH);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [SUM_WIDTH-1:0]    sum_t;
    typedef logic        [CNT_WIDTH-1:0]    count_t;

    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    typedef enum logic {
        MODE_MAX = 1'b0,
        MODE_AVG = 1'b1
    } pool_mode_t;

    typedef enum logic {
        ST_ACCUM = 1'b0,
        ST_DIV   = 1'b1
    } mgp_state_t;

endpackage

// ===== design/masked_global_pooling.sv =====
// Masked global pooling: accumulates max, sum and count over a plane and, in average mode, divides at its end.
// Depends on mgp_pkg for widths, constants and the sequencer state type.
//
// One request carries a signed Q8.8 sample, a mask bit and an end-of-plane mark, and
// requests are taken while s_ready is high and the block accumulates a plane. Samples whose mask
// bit is 0 are ignored. The request that closes a plane produces one result: in max mode
// (pool_mode = 0), or for a plane with no valid samples, the result is ready in the cycle
// after that request. In average mode (pool_mode = 1) a restoring divider, one quotient bit
// per cycle through a single shared subtractor, turns the sum into the average, truncated
// toward zero; the divider steps through all SUM_WIDTH quotient bits, during which s_ready
// is low. An empty plane returns 0 in average mode and the most negative value in max
// mode, with m_empty_plane set. Only the first MAX_PLANE_ELEMENTS valid samples enter the
// average, while the max covers all of them. The result sits in an output register; while it
// waits for m_ready, s_ready is low and no request is taken, so a stalled receiver stalls
// the input. pool_mode is written through cfg_wr_en/cfg_wr_data and is taken at the
// request that closes a plane.
module masked_global_pooling
    import mgp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,

    input  logic    cfg_wr_en,
    input  logic    cfg_wr_data,

    input  logic    s_valid,
    output logic    s_ready,
    input  sample_t s_sample,
    input  logic    s_valid_req,
    input  logic    s_last_in_plane,

    output logic    m_valid,
    input  logic    m_ready,
    output sample_t m_pooled_value,
    output logic    m_empty_plane
);

    mgp_state_t state_reg, state_next;
    pool_mode_t mode_reg;

    // Plane accumulators.
    sample_t max_reg;
    sum_t    sum_reg;
    count_t  count_reg;

    // Divider registers: partial remainder, dividend shifting into the quotient, result sign.
    count_t               rem_reg;
    logic [SUM_WIDTH-1:0] quo_reg;
    logic                 neg_reg;
    logic [STEP_WIDTH-1:0] step_reg;

    // Output register.
    logic    m_valid_reg;
    sample_t m_value_reg;
    logic    m_empty_reg;

    logic    accept;
    logic    take_sample;
    logic    cnt_full;
    sample_t max_upd;
    sum_t    sum_upd;
    count_t  count_upd;
    logic    go_div;
    logic    div_done;
    logic    close_direct;
    logic [SUM_WIDTH-1:0] sum_mag;

    logic [CNT_WIDTH:0]   rem_shift;
    logic [CNT_WIDTH+1:0] trial;
    logic                 q_bit;
    count_t               rem_next;
    logic [SUM_WIDTH-1:0] quo_next;
    logic [SUM_WIDTH-1:0] avg_full;

    // ------------------------------------------------------------------
    // Accumulation of the current request.
    // ------------------------------------------------------------------
    assign accept      = s_valid && s_ready;
    assign take_sample = s_valid_req;
    assign cnt_full    = (count_reg == CNT_WIDTH'(MAX_PLANE_ELEMENTS));

    always_comb begin
        max_upd   = max_reg;
        sum_upd   = sum_reg;
        count_upd = count_reg;
        if (take_sample) begin
            if (s_sample > max_reg) begin
                max_upd = s_sample;
            end
            if (!cnt_full) begin
                sum_upd   = sum_reg + sum_t'(s_sample);
                count_upd = count_reg + count_t'(1);
            end
        end
    end

    // Magnitude of the sum; the divider works on magnitudes and fixes the sign at the end.
    assign sum_mag = sum_upd[SUM_WIDTH-1] ? (SUM_WIDTH'(0) - sum_upd) : sum_upd;

    // A closing request goes to the divider only in average mode with at least one sample.
    assign go_div       = accept && s_last_in_plane && (mode_reg == MODE_AVG)
                          && (count_upd != '0);
    assign close_direct = accept && s_last_in_plane && !go_div;

    // ------------------------------------------------------------------
    // Shared subtractor: one restoring division step per cycle.
    // ------------------------------------------------------------------
    assign rem_shift = {rem_reg, quo_reg[SUM_WIDTH-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, count_reg};
    assign q_bit     = !trial[CNT_WIDTH+1];
    assign rem_next  = q_bit ? trial[CNT_WIDTH-1:0] : rem_shift[CNT_WIDTH-1:0];
    assign quo_next  = {quo_reg[SUM_WIDTH-2:0], q_bit};
    assign avg_full  = neg_reg ? (SUM_WIDTH'(0) - quo_next) : quo_next;

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACCUM: begin
                if (go_div) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (step_reg == '0) begin
                    state_next = ST_ACCUM;
                end
            end
            default: state_next = ST_ACCUM;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        div_done = 1'b0;
        unique case (state_reg)
            ST_ACCUM: s_ready  = !m_valid_reg || m_ready;
            ST_DIV:   div_done = (step_reg == '0);
            default: begin
                s_ready  = 1'b0;
                div_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCUM;
            mode_reg  <= MODE_MAX;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                mode_reg <= pool_mode_t'(cfg_wr_data);
            end
        end
    end

    // ------------------------------------------------------------------
    // Accumulators and divider. The sum and count stay in place while the
    // divider runs and are cleared when it finishes.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg   <= SAMPLE_MIN;
            sum_reg   <= '0;
            count_reg <= '0;
        end else if (accept) begin
            if (go_div) begin
                max_reg   <= SAMPLE_MIN;
                sum_reg   <= sum_upd;
                count_reg <= count_upd;
            end else if (s_last_in_plane) begin
                max_reg   <= SAMPLE_MIN;
                sum_reg   <= '0;
                count_reg <= '0;
            end else begin
                max_reg   <= max_upd;
                sum_reg   <= sum_upd;
                count_reg <= count_upd;
            end
        end else if (div_done) begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (go_div) begin
            rem_reg  <= '0;
            quo_reg  <= sum_mag;
            neg_reg  <= sum_upd[SUM_WIDTH-1];
            step_reg <= STEP_WIDTH'(SUM_WIDTH - 1);
        end else if (state_reg == ST_DIV) begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            step_reg <= step_reg - STEP_WIDTH'(1);
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (close_direct || div_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (close_direct) begin
            m_empty_reg <= (count_upd == '0);
            if (mode_reg == MODE_MAX) begin
                m_value_reg <= max_upd;
            end else begin
                m_value_reg <= '0;
            end
        end else if (div_done) begin
            m_empty_reg <= 1'b0;
            m_value_reg <= avg_full[SAMPLE_WIDTH-1:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pooled_value = m_value_reg;
    assign m_empty_plane  = m_empty_reg;

endmodule

// ===== design/mgp_checker.sv =====
// Port-level checker for masked_global_pooling, attached by the bind at the end of this file.
// Depends on mgp_pkg for the sample type and its most negative value.
module mgp_checker
    import mgp_pkg::*;
(
    input logic    aclk,
    input logic    aresetn,
    input logic    s_valid,
    input logic    s_ready,
    input logic    s_last_in_plane,
    input logic    m_valid,
    input logic    m_ready,
    input sample_t m_pooled_value,
    input logic    m_empty_plane
);

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pooled_value) && $stable(m_empty_plane))
        else $error("stalled result changed");

    // An empty plane gives zero or the most negative value, nothing else.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_empty_plane |-> (m_pooled_value == '0 || m_pooled_value == SAMPLE_MIN))
        else $error("empty plane with an unexpected value");

    // A request that does not close a plane never produces a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_last_in_plane && !(m_valid && !m_ready) |=> !m_valid)
        else $error("result without a closing request");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind masked_global_pooling mgp_checker u_mgp_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_last_in_plane (s_last_in_plane),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_pooled_value  (m_pooled_value),
    .m_empty_plane   (m_empty_plane)
);

// ===== sim/masked_global_pooling_tb.sv =====
// Self-checking testbench for masked_global_pooling: streams samples with mask and end-of-plane
// marks, predicts each pooled result and compares it field by field. Depends on mgp_pkg and on
// the masked_global_pooling RTL.
module masked_global_pooling_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mgp_pkg::*;

    localparam sample_t SAMPLE_MAX    = ~SAMPLE_MIN;
    // The slowest result is an average, which waits for the divider after the
    // closing request. Idle waits before a mode write and at the end add a small margin.
    localparam int      SETTLE_CYCLES = SUM_WIDTH + 8;
    // Cycles with no accepted request on either side before the run is declared hung.
    localparam int      IDLE_LIMIT    = 2000;
    // Length of the one long receiver hold-off.
    localparam int      LONG_HOLD     = 400;
    localparam int      PHASE_ITEMS   = 325;

    typedef struct packed {
        sample_t value;
        logic    empty;
    } pooled_result_t;

    typedef enum {
        RX_ALWAYS,
        RX_RANDOM,
        RX_RUNS
    } rx_pattern_t;

    // Keeps its own copy of the plane accumulators and the mode, predicts the pooled result
    // for every closing request and holds the predictions until the block delivers them.
    class plane_pool_checker;
        pool_mode_t     pool_mode;
        sample_t        plane_max;
        sum_t           plane_sum;
        count_t         plane_count;
        pooled_result_t expected_pools[$];
        int             requests_seen;
        int             planes_closed;
        int             empty_planes;
        int             avg_planes;
        int             errors;

        function new();
            pool_mode     = MODE_MAX;
            requests_seen = 0;
            planes_closed = 0;
            empty_planes  = 0;
            avg_planes    = 0;
            errors        = 0;
            clear_plane();
        endfunction

        function void clear_plane();
            plane_max   = SAMPLE_MIN;
            plane_sum   = '0;
            plane_count = '0;
        endfunction

        // Called once per accepted request.
        function void absorb_sample(sample_t value, logic use_it, logic closes);
            pooled_result_t pooled;
            sum_t           quotient;
            requests_seen++;
            if (use_it) begin
                // The max follows every valid sample, the sum and count stop at the limit.
                if (value > plane_max) begin
                    plane_max = value;
                end
                if (plane_count < MAX_PLANE_ELEMENTS) begin
                    plane_sum += value;
                    plane_count++;
                end
            end
            if (closes) begin
                pooled.empty = (plane_count == 0);
                if (pool_mode == MODE_MAX) begin
                    pooled.value = plane_max;
                end else if (plane_count == 0) begin
                    pooled.value = '0;
                end else begin
                    // Signed division truncates toward zero.
                    quotient     = plane_sum / sum_t'(plane_count);
                    pooled.value = quotient[SAMPLE_WIDTH-1:0];
                end
                expected_pools.push_back(pooled);
                planes_closed++;
                if (pooled.empty) begin
                    empty_planes++;
                end
                if (pool_mode == MODE_AVG) begin
                    avg_planes++;
                end
                clear_plane();
            end
        endfunction

        // Called once per accepted result.
        function void check_pooled(sample_t got_value, logic got_empty);
            pooled_result_t want;
            if (expected_pools.size() == 0) begin
                $error("result with no plane pending: pooled_value %0d, empty_plane %0b",
                       got_value, got_empty);
                errors++;
                return;
            end
            want = expected_pools.pop_front();
            if (got_value !== want.value) begin
                $error("pooled_value: expected %0d, actual %0d",
                       $signed(want.value), $signed(got_value));
                errors++;
            end
            if (got_empty !== want.empty) begin
                $error("empty_plane: expected %0b, actual %0b", want.empty, got_empty);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    sample_t     s_sample;
    logic        s_valid_req;
    logic        s_last_in_plane;
    logic        m_valid;
    logic        m_ready;
    sample_t     m_pooled_value;
    logic        m_empty_plane;

    plane_pool_checker tracker;

    // Sender and receiver pacing, set by the stimulus per phase.
    bit          tx_bursty = 1'b1;
    int          burst_left = 0;
    rx_pattern_t rx_style = RX_ALWAYS;
    // Set by the stimulus, counted down by the receiver itself.
    int          long_hold_cycles = 0;
    int          stalls_in_hold = 0;

    masked_global_pooling dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .s_valid_req     (s_valid_req),
        .s_last_in_plane (s_last_in_plane),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pooled_value  (m_pooled_value),
        .m_empty_plane   (m_empty_plane)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Offers one request from a falling edge and holds it until it is accepted at a rising
    // edge. In bursty mode a random gap opens once the current burst is used up. Returns at
    // the falling edge after acceptance, so the next request can follow back to back.
    task automatic send_request(input sample_t value, input logic use_it, input logic closes);
        if (tx_bursty) begin
            if (burst_left == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        s_valid         <= 1'b1;
        s_sample        <= value;
        s_valid_req     <= use_it;
        s_last_in_plane <= closes;
        do @(posedge aclk); while (s_ready !== 1'b1);
        tracker.absorb_sample(value, use_it, closes);
        @(negedge aclk);
    endtask

    // Lets every pending result drain, then waits out a full divide so the block is idle.
    task automatic settle();
        s_valid <= 1'b0;
        while (tracker.expected_pools.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_pool_mode(input pool_mode_t mode);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        tracker.pool_mode = mode;
    endtask

    // Value styles: full random, extremes and ones around zero, small signed values.
    function automatic sample_t pick_sample(int style);
        sample_t corners [5];
        corners = '{SAMPLE_MIN, SAMPLE_MAX, -16'sd1, 16'sd0, 16'sd1};
        case (style)
            0: return sample_t'($urandom);
            1: return corners[$urandom_range(0, 4)];
            2: return sample_t'($urandom_range(0, 512)) - 16'sd256;
            default: return pick_sample($urandom_range(0, 2));
        endcase
    endfunction

    // One plane of random length, mask density and value style. Most planes are short; a
    // tenth of them run longer so the sum and count get some depth.
    task automatic send_random_plane();
        int   len;
        int   mask_kind;
        int   value_kind;
        logic use_it;
        len        = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
        mask_kind  = $urandom_range(0, 5);
        value_kind = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) begin
            case (mask_kind)
                0, 1: use_it = 1'b1;
                2: use_it = 1'b0;
                3: use_it = ($urandom_range(0, 7) != 0);
                default: use_it = 1'($urandom_range(0, 1));
            endcase
            send_request(pick_sample(value_kind), use_it, i == len - 1);
        end
    endtask

    // Short planes that hit the field extremes, the empty plane, a masked closing sample, a
    // valid closing sample, an all-negative max and truncation toward zero on both signs.
    task automatic run_directed_planes();
        send_request(16'sd0, 1'b0, 1'b1);
        send_request(SAMPLE_MAX, 1'b1, 1'b1);
        send_request(SAMPLE_MIN, 1'b1, 1'b1);
        send_request(16'sd5, 1'b1, 1'b0);
        send_request(-16'sd3, 1'b0, 1'b0);
        send_request(16'sd8, 1'b1, 1'b0);
        send_request(SAMPLE_MAX, 1'b0, 1'b1);
        send_request(-16'sd3, 1'b1, 1'b0);
        send_request(-16'sd4, 1'b1, 1'b1);
        send_request(-16'sd5, 1'b1, 1'b0);
        send_request(-16'sd2, 1'b1, 1'b0);
        send_request(-16'sd9, 1'b1, 1'b1);
    endtask

    // Receiver: drives m_ready at falling edges. A requested long hold-off takes priority
    // and is counted down here; otherwise the phase picks always-ready, random stalls, or
    // alternating runs of ready and stall with random lengths.
    initial begin
        int   run_left;
        logic run_ready;
        run_left  = 0;
        run_ready = 1'b1;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_cycles > 0) begin
                long_hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                case (rx_style)
                    RX_ALWAYS: m_ready <= 1'b1;
                    RX_RANDOM: m_ready <= ($urandom_range(0, 9) < 7);
                    default: begin
                        if (run_left == 0) begin
                            run_ready = !run_ready;
                            run_left  = run_ready ? $urandom_range(1, 6) : $urandom_range(1, 10);
                        end
                        run_left--;
                        m_ready <= run_ready;
                    end
                endcase
            end
        end
    end

    // Every accepted result is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_pooled(m_pooled_value, m_empty_plane);
        end
    end

    // Watchdog: ends the run once the quiet count, cleared by any request that moves on either
    // side, reaches IDLE_LIMIT. It also counts the cycles in which the input is held back during the long hold-off.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (long_hold_cycles > 0 && s_valid && !s_ready) begin
                stalls_in_hold++;
            end
        end
        $error("no request moved for %0d cycles", IDLE_LIMIT);
        $display("** masked_global_pooling: FAILED **");
        $finish;
    end

    initial begin
        int mark;
        tracker         = new();
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = 1'b0;
        s_valid         = 1'b0;
        s_sample        = '0;
        s_valid_req     = 1'b0;
        s_last_in_plane = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed planes in max mode, relying on the reset value of the mode register.
        rx_style = RX_RUNS;
        run_directed_planes();

        // Mode change in the middle of a plane: only the mode at the closing request counts,
        // so this plane comes out as the average (20 - 10 + 1) / 3 = 3.
        send_request(16'sd20, 1'b1, 1'b0);
        send_request(-16'sd10, 1'b1, 1'b0);
        settle();
        write_pool_mode(MODE_AVG);
        send_request(16'sd1, 1'b1, 1'b1);

        // Same directed planes in average mode.
        run_directed_planes();
        settle();

        // Random phases with alternating mode and different pacing on both sides. The first
        // one has no idling at all; the second one includes the long receiver hold-off while
        // the sender keeps pushing back to back, so the output register fills and the
        // closing requests back up into the input.
        for (int phase = 0; phase < 4; phase++) begin
            write_pool_mode((phase % 2 == 0) ? MODE_AVG : MODE_MAX);
            tx_bursty = (phase != 0);
            case (phase)
                0: rx_style = RX_ALWAYS;
                2: rx_style = RX_RUNS;
                default: rx_style = RX_RANDOM;
            endcase
            mark = tracker.requests_seen;
            if (phase == 1) begin
                tx_bursty        = 1'b0;
                long_hold_cycles = LONG_HOLD;
                while (long_hold_cycles > 0) begin
                    send_random_plane();
                end
                tx_bursty = 1'b1;
            end
            while (tracker.requests_seen - mark < PHASE_ITEMS) begin
                send_random_plane();
            end
            settle();
        end

        $display("Streamed %0d samples in %0d planes: %0d in average mode, %0d empty.",
                 tracker.requests_seen, tracker.planes_closed, tracker.avg_planes,
                 tracker.empty_planes);
        $display("Both modes ran with stalls on each side; input held back %0d cycles in hold-off.",
                 stalls_in_hold);
        if (tracker.errors == 0 && tracker.expected_pools.size() == 0) begin
            $display("** masked_global_pooling: PASSED **");
        end else begin
            $display("** masked_global_pooling: FAILED **");
        end
        $finish;
    end

endmodule
